[hw/rtl/pip_pkg.sv]
`default_nettype none

package pip_pkg;

  // per-item control that travels with the edge operands
  typedef struct packed {
    logic last;
    logic en0;
    logic en1;
  } edge_ctl_t;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 1'b1;

  // operands per edge: qx-xi, yj-yi, xj-xi, qy-yi
  localparam int OPS_PER_EDGE = 4;
  localparam int EDGES        = 2;

endpackage

`default_nettype wire

[hw/rtl/point_in_polygon_test.sv]
`default_nettype none

// Even-odd point-in-polygon test. Set query_x / query_y (register 0 / 1) while idle, then
// push the polygon one vertex per item, marking the final one with last_vertex; one
// inside_res item comes out per polygon. One vertex is accepted every cycle while full is low. The front
// stage forms the edge operands combinationally and writes them into the edge queue at the
// accepting edge; the back pops them into the registered multiplier stage and resolves the
// crossing into the result queue, popping only while the result queue has room for every
// item in flight. Unread results fill the result queue, then the edge queue, and full rises.
// Throughput is set by the four parallel (COORD_BITS+1)-bit multipliers, one vertex per
// cycle while full is low.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int MID_DEPTH  = 4,
  parameter int OUT_DEPTH  = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [COORD_BITS-1:0] vert_x,
  input  wire logic [COORD_BITS-1:0] vert_y,
  input  wire logic                  last_vertex,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       inside_res
);

  localparam int DATA_W = EDGES * OPS_PER_EDGE * (COORD_BITS + 1);
  localparam int Q_W    = $bits(edge_ctl_t) + DATA_W;

  logic                          accept;
  edge_ctl_t                     f_ctl;
  logic [DATA_W-1:0]             f_data;
  logic [Q_W-1:0]                q_dout;
  logic                          q_empty;
  logic                          q_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] q_cnt;
  edge_ctl_t                     q_ctl;
  logic [DATA_W-1:0]             q_data;

  assign accept = push && !full;
  assign q_ctl  = q_dout[Q_W-1 -: $bits(edge_ctl_t)];
  assign q_data = q_dout[DATA_W-1:0];

  pip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .last_vertex (last_vertex),
    .accept      (accept),
    .ctl         (f_ctl),
    .data        (f_data)
  );

  pip_queue #(
    .WIDTH (Q_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   ({f_ctl, f_data}),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_cnt)
  );

  logic unused_cnt;
  assign unused_cnt = ^q_cnt;

  pip_back #(
    .COORD_BITS (COORD_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_ctl      (q_ctl),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .inside_res (inside_res)
  );

endmodule

`default_nettype wire

[hw/rtl/pip_queue.sv]
`default_nettype none

module pip_queue
  import pip_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           din,
  output logic                            full,
  input  wire logic                       pop,
  output logic [WIDTH-1:0]                dout,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign count   = cnt;
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + CNT_W'(1);
        2'b01:   cnt <= cnt - CNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pip_front.sv]
`default_nettype none

module pip_front
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                   cfg_idx,
  input  wire logic [COORD_BITS-1:0]                  cfg_data,
  input  wire logic [COORD_BITS-1:0]                  vert_x,
  input  wire logic [COORD_BITS-1:0]                  vert_y,
  input  wire logic                                   last_vertex,
  input  wire logic                                   accept,
  output edge_ctl_t                                   ctl,
  output logic [EDGES*OPS_PER_EDGE*(COORD_BITS+1)-1:0] data
);

  localparam int D = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] first_vx;
  logic signed [COORD_BITS-1:0] first_vy;
  logic signed [COORD_BITS-1:0] prev_vx;
  logic signed [COORD_BITS-1:0] prev_vy;
  logic                         seen_first;

  logic signed [COORD_BITS-1:0] vx;
  logic signed [COORD_BITS-1:0] vy;
  logic signed [COORD_BITS-1:0] fx;
  logic signed [COORD_BITS-1:0] fy;
  logic signed [D-1:0]          ex_q;
  logic signed [D-1:0]          ey_q;
  logic signed [D-1:0]          ex_v;
  logic signed [D-1:0]          ey_v;
  logic signed [D-1:0]          ex_p;
  logic signed [D-1:0]          ey_p;
  logic signed [D-1:0]          ex_f;
  logic signed [D-1:0]          ey_f;

  assign vx = vert_x;
  assign vy = vert_y;
  assign fx = seen_first ? first_vx : vx;
  assign fy = seen_first ? first_vy : vy;

  assign ex_q = {query_x[COORD_BITS-1], query_x};
  assign ey_q = {query_y[COORD_BITS-1], query_y};
  assign ex_v = {vx[COORD_BITS-1], vx};
  assign ey_v = {vy[COORD_BITS-1], vy};
  assign ex_p = {prev_vx[COORD_BITS-1], prev_vx};
  assign ey_p = {prev_vy[COORD_BITS-1], prev_vy};
  assign ex_f = {fx[COORD_BITS-1], fx};
  assign ey_f = {fy[COORD_BITS-1], fy};

  // edge 0: current -> previous; edge 1: first -> current (closing)
  always_comb begin
    ctl.last = last_vertex;
    ctl.en0  = seen_first && ((vy > query_y) != (prev_vy > query_y));
    ctl.en1  = last_vertex && ((fy > query_y) != (vy > query_y));
    data = {ey_q - ey_f, ex_v - ex_f, ey_v - ey_f, ex_q - ex_f,
            ey_q - ey_v, ex_p - ex_v, ey_p - ey_v, ex_q - ex_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_QUERY_X: query_x <= cfg_data;
        REG_QUERY_Y: query_y <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first <= 1'b0;
    end else if (accept) begin
      seen_first <= !last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!seen_first) begin
        first_vx <= vx;
        first_vy <= vy;
      end
      prev_vx <= vx;
      prev_vy <= vy;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pip_back.sv]
`default_nettype none

module pip_back
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int OUT_DEPTH  = 4
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    q_empty,
  input  wire edge_ctl_t                               q_ctl,
  input  wire logic [EDGES*OPS_PER_EDGE*(COORD_BITS+1)-1:0] q_data,
  output logic                                         q_pop,
  output logic                                         empty,
  input  wire logic                                    pop,
  output logic                                         inside_res
);

  localparam int D     = COORD_BITS + 1;
  localparam int P     = 2 * D;
  localparam int CNT_W = $clog2(OUT_DEPTH+1);

  logic signed [D-1:0] a0, b0, c0, d0, a1, b1, c1, d1;

  logic                s1_valid;
  logic                s1_last;
  logic                s1_en0;
  logic                s1_en1;
  logic                s1_neg0;
  logic                s1_neg1;
  logic signed [P-1:0] s1_l0, s1_r0, s1_l1, s1_r1;

  logic                parity;
  logic                flip0;
  logic                flip1;
  logic                parity_next;
  logic                out_push;
  logic                out_full;
  logic [CNT_W-1:0]    out_cnt;

  assign a0 = q_data[0*D +: D];
  assign b0 = q_data[1*D +: D];
  assign c0 = q_data[2*D +: D];
  assign d0 = q_data[3*D +: D];
  assign a1 = q_data[4*D +: D];
  assign b1 = q_data[5*D +: D];
  assign c1 = q_data[6*D +: D];
  assign d1 = q_data[7*D +: D];

  // room for every item in flight before taking another
  assign q_pop = !q_empty &&
                 ((CNT_W+1)'(out_cnt) + (CNT_W+1)'(s1_valid) < (CNT_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_last <= q_ctl.last;
      s1_en0  <= q_ctl.en0;
      s1_en1  <= q_ctl.en1;
      s1_neg0 <= b0[D-1];
      s1_neg1 <= b1[D-1];
      s1_l0   <= a0 * b0;
      s1_r0   <= c0 * d0;
      s1_l1   <= a1 * b1;
      s1_r1   <= c1 * d1;
    end
  end

  assign flip0 = s1_en0 && (s1_neg0 ? (s1_l0 > s1_r0) : (s1_l0 < s1_r0));
  assign flip1 = s1_en1 && (s1_neg1 ? (s1_l1 > s1_r1) : (s1_l1 < s1_r1));
  assign parity_next = parity ^ flip0 ^ flip1;
  assign out_push    = s1_valid && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (s1_valid) begin
      parity <= s1_last ? 1'b0 : parity_next;
    end
  end

  pip_queue #(
    .WIDTH (1),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (parity_next),
    .full  (out_full),
    .pop   (pop),
    .dout  (inside_res),
    .empty (empty),
    .count (out_cnt)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule

`default_nettype wire

[hw/rtl/pip_checker.sv]
`default_nettype none

module pip_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire logic inside_res
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted item");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(inside_res))
    else $error("waiting result changed");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .inside_res (inside_res)
);

`default_nettype wire
